### design/cmwc_pkg.sv
// ----------------------------------------------------------------------------
// cmwc_pkg
// Shared constants and types of the CMWC random number generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cmwc_pkg;

  localparam int unsigned LAG_SIZE = 4096;
  localparam int unsigned POS_W    = (LAG_SIZE > 1) ? $clog2(LAG_SIZE) : 1;
  localparam int unsigned WORD_W   = 32;

  localparam logic [WORD_W-1:0] LCG_MUL     = 32'd1103515245;
  localparam logic [WORD_W-1:0] LCG_ADD     = 32'd12345;
  localparam logic [WORD_W-1:0] CARRY_LIMIT = 32'd809430660;
  localparam logic [WORD_W-1:0] CMWC_MUL    = 32'd18782;
  localparam logic [WORD_W-1:0] CMWC_BASE   = 32'hffff_fffe;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LAG_SIZE - 1);

  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [2*WORD_W-1:0] dword_t;
  typedef logic [POS_W-1:0]    pos_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_MOD,
    ST_READ,
    ST_MUL,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

### design/cmwc_random_generator_unit.sv
// ----------------------------------------------------------------------------
// cmwc_random_generator_unit
// Complementary multiply-with-carry generator with a lag table in memory.
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  input   | in_valid, in_stall, in_kind, in_seed | in (in_stall out)
//  result  | out_valid, out_stall, out_value     | out (out_stall in)
//
//  Draw: accept, table read, multiply-add and finish steps through one
//  shared multiply-add unit and the table's single read port.
//  Reseed: a fill pass over all LAG_SIZE table entries, one LCG step and one
//  table write each, then compare-subtract reduction for the carry.
//  Reset: no clearing pass; the table is undefined until the first reseed.
//  A stalled result holds in the output register; a draw waits at finish.
// ----------------------------------------------------------------------------
`default_nettype none

module cmwc_random_generator_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [0:0]  in_kind,
  input  wire  [31:0] in_seed,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_value
);

  cmwc_pkg::state_t state_r, state_nxt;
  cmwc_pkg::word_t  v_r, v_nxt;
  cmwc_pkg::pos_t   idx_r, idx_nxt;
  cmwc_pkg::word_t  carry_r, carry_nxt;
  cmwc_pkg::pos_t   pos_r, pos_nxt;
  cmwc_pkg::dword_t t_r, t_nxt;
  cmwc_pkg::word_t  out_value_r, out_value_nxt;
  logic             out_valid_r, out_valid_nxt;
  cmwc_pkg::word_t  rd_data_r;

  cmwc_pkg::word_t  lag_mem [cmwc_pkg::LAG_SIZE];

  logic             mem_we;
  cmwc_pkg::pos_t   mem_wa;
  cmwc_pkg::word_t  mem_wd;

  cmwc_pkg::word_t  mac_a, mac_b, mac_c;
  cmwc_pkg::dword_t mac_p;

  logic [32:0]      sum;
  cmwc_pkg::word_t  hi_w, x_w, c_w, res_w;
  logic             in_xfer;

  cmwc_mac u_mac (
    .a (mac_a),
    .b (mac_b),
    .c (mac_c),
    .p (mac_p)
  );

  assign in_stall  = (state_r != cmwc_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  always_comb begin
    hi_w  = t_r[63:32];
    sum   = {1'b0, t_r[31:0]} + {1'b0, hi_w};
    if (sum[32]) begin
      x_w = sum[31:0] + 32'd1;
      c_w = hi_w + 32'd1;
    end else begin
      x_w = sum[31:0];
      c_w = hi_w;
    end
    res_w = cmwc_pkg::CMWC_BASE - x_w;
  end

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    idx_nxt       = idx_r;
    carry_nxt     = carry_r;
    pos_nxt       = pos_r;
    t_nxt         = t_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_wa        = pos_r;
    mem_wd        = res_w;
    mac_a         = rd_data_r;
    mac_b         = cmwc_pkg::CMWC_MUL;
    mac_c         = carry_r;

    unique case (state_r)
      cmwc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_kind[0] == cmwc_pkg::KIND_RESEED) begin
            v_nxt     = in_seed;
            idx_nxt   = '0;
            state_nxt = cmwc_pkg::ST_FILL;
          end else begin
            pos_nxt   = (pos_r == cmwc_pkg::POS_LAST) ? '0 : pos_r + 1'b1;
            state_nxt = cmwc_pkg::ST_READ;
          end
        end
      end
      cmwc_pkg::ST_FILL: begin
        mac_a  = v_r;
        mac_b  = cmwc_pkg::LCG_MUL;
        mac_c  = cmwc_pkg::LCG_ADD;
        mem_we = 1'b1;
        mem_wa = idx_r;
        mem_wd = v_r;
        v_nxt  = mac_p[31:0];
        if (idx_r == cmwc_pkg::POS_LAST) begin
          state_nxt = cmwc_pkg::ST_MOD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      cmwc_pkg::ST_MOD: begin
        if (v_r >= cmwc_pkg::CARRY_LIMIT) begin
          v_nxt = v_r - cmwc_pkg::CARRY_LIMIT;
        end else begin
          carry_nxt = v_r;
          pos_nxt   = cmwc_pkg::POS_LAST;
          state_nxt = cmwc_pkg::ST_IDLE;
        end
      end
      cmwc_pkg::ST_READ: begin
        state_nxt = cmwc_pkg::ST_MUL;
      end
      cmwc_pkg::ST_MUL: begin
        t_nxt     = mac_p;
        state_nxt = cmwc_pkg::ST_FIN;
      end
      cmwc_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          mem_we        = 1'b1;
          carry_nxt     = c_w;
          out_value_nxt = res_w;
          out_valid_nxt = 1'b1;
          state_nxt     = cmwc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cmwc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cmwc_pkg::ST_IDLE;
      carry_r     <= '0;
      pos_r       <= cmwc_pkg::POS_LAST;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      carry_r     <= carry_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    t_r         <= t_nxt;
    out_value_r <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lag_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= lag_mem[pos_r];
  end

endmodule

`default_nettype wire

### design/cmwc_mac.sv
// ----------------------------------------------------------------------------
// cmwc_mac
// Shared multiply-add unit: p = a * b + c, full 64-bit result.
// ----------------------------------------------------------------------------
`default_nettype none

module cmwc_mac (
  input  wire cmwc_pkg::word_t  a,
  input  wire cmwc_pkg::word_t  b,
  input  wire cmwc_pkg::word_t  c,
  output cmwc_pkg::dword_t      p
);

  assign p = (cmwc_pkg::dword_t'(a) * cmwc_pkg::dword_t'(b)) + cmwc_pkg::dword_t'(c);

endmodule

`default_nettype wire
